// ===== rtl/fcr_pkg.sv =====
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared types and constants for the conductor Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fcr_pkg;

  localparam int NUM_FIELD_CH = 3;

  localparam logic [27:0] RATIO_SQ_MAX = 28'hFFF_FFFF;
  localparam logic [16:0] ONE_Q16      = 17'h1_0000;
  localparam logic [15:0] ONE_Q15      = 16'h8000;

  typedef struct packed {
    logic [15:0]        eta_out_0;
    logic [15:0]        eta_out_1;
    logic [15:0]        eta_out_2;
    logic [15:0]        eta_in_0;
    logic [15:0]        eta_in_1;
    logic [15:0]        eta_in_2;
    logic [15:0]        absorb_0;
    logic [15:0]        absorb_1;
    logic [15:0]        absorb_2;
    logic signed [15:0] cos_theta;
  } item_t;

  typedef struct packed {
    logic [15:0] refl_0;
    logic [15:0] refl_1;
    logic [15:0] refl_2;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/fcr_div.sv =====
// ----------------------------------------------------------------------------
// fcr_div
// Pipelined restoring divider, one quotient bit per stage. The numerator
// must be below den << Q_W. One transfer per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_div #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 32,
  parameter int Q_W    = 28,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [Q_W-1:0]    quo,
  output logic [SIDE_W-1:0] side_out
);

  logic [DEN_W-1:0]  rem    [Q_W+1];
  logic [Q_W-1:0]    quo_s  [Q_W+1];
  logic [Q_W-1:0]    low    [Q_W+1];
  logic [DEN_W-1:0]  den_s  [Q_W+1];
  logic [SIDE_W-1:0] side_s [Q_W+1];
  logic              vld    [Q_W+1];

  assign rem[0]    = DEN_W'(num >> Q_W);
  assign quo_s[0]  = '0;
  assign low[0]    = num[Q_W-1:0];
  assign den_s[0]  = den;
  assign side_s[0] = side_in;
  assign vld[0]    = in_valid;

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [DEN_W:0] acc;
    logic [DEN_W:0] diff;
    logic           ge;

    assign acc  = {rem[k], low[k][Q_W-1-k]};
    assign diff = acc - {1'b0, den_s[k]};
    assign ge   = (acc >= {1'b0, den_s[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      rem[k+1]    <= ge ? diff[DEN_W-1:0] : acc[DEN_W-1:0];
      quo_s[k+1]  <= {quo_s[k][Q_W-2:0], ge};
      low[k+1]    <= low[k];
      den_s[k+1]  <= den_s[k];
      side_s[k+1] <= side_s[k];
    end
  end

  assign out_valid = vld[Q_W];
  assign quo       = quo_s[Q_W];
  assign side_out  = side_s[Q_W];

endmodule

`default_nettype wire

// ===== rtl/fcr_sqrt.sv =====
// ----------------------------------------------------------------------------
// fcr_sqrt
// Pipelined integer square root (floor), one root bit per stage.
// One transfer per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_sqrt #(
  parameter int IN_W   = 59,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [IN_W-1:0]          x,
  input  logic [SIDE_W-1:0]        side_in,
  output logic                     out_valid,
  output logic [(IN_W+1)/2-1:0]    root,
  output logic [SIDE_W-1:0]        side_out
);

  localparam int R_W = (IN_W + 1) / 2;
  localparam int X_W = 2 * R_W;

  logic [X_W-1:0]    xs     [R_W+1];
  logic [R_W+1:0]    rem    [R_W+1];
  logic [R_W-1:0]    rt     [R_W+1];
  logic [SIDE_W-1:0] side_s [R_W+1];
  logic              vld    [R_W+1];

  assign xs[0]     = X_W'(x);
  assign rem[0]    = '0;
  assign rt[0]     = '0;
  assign side_s[0] = side_in;
  assign vld[0]    = in_valid;

  for (genvar k = 0; k < R_W; k++) begin : g_step
    logic [R_W+3:0] acc;
    logic [R_W+3:0] trial;
    logic [R_W+3:0] diff;
    logic           ge;

    assign acc   = {rem[k], xs[k][X_W-1-2*k -: 2]};
    assign trial = (R_W + 4)'({rt[k], 2'b01});
    assign diff  = acc - trial;
    assign ge    = (acc >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      rem[k+1]    <= ge ? diff[R_W+1:0] : acc[R_W+1:0];
      rt[k+1]     <= {rt[k][R_W-2:0], ge};
      xs[k+1]     <= xs[k];
      side_s[k+1] <= side_s[k];
    end
  end

  assign out_valid = vld[R_W];
  assign root      = rt[R_W];
  assign side_out  = side_s[R_W];

endmodule

`default_nettype wire

// ===== rtl/conductor_fresnel_reflectance.sv =====
// ----------------------------------------------------------------------------
// conductor_fresnel_reflectance
// Unpolarised Fresnel reflectance of a conductor for up to three channels.
//
// Input: an item (indices Q4.12 per channel, cosine Q1.15) is transferred on
// each rising edge with start high and busy low. busy is always low: the
// pipeline takes one item every cycle with no gaps.
// Output: each result is on result for one cycle with done high, and
// results leave in input order.
// The pipeline is a chain of bit-per-stage units: two 28-bit dividers in
// parallel, a 30-bit and a 23-bit square root, two 17-bit dividers in
// parallel, plus 13 arithmetic and output register stages.
// Throughput: one item per cycle. The receiver cannot stall the block.
// Reset clears every valid bit; data registers hold garbage until flushed.
// Cosine at or below zero gives zero reflectance; channels at or above
// CHANNELS read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module conductor_fresnel_reflectance #(
  parameter int CHANNELS = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  fcr_pkg::item_t   item,
  output logic             done,
  output fcr_pkg::result_t result
);

  import fcr_pkg::*;

  localparam int EK_Q_W = 28;
  localparam int X1_W   = 59;
  localparam int X2_W   = 46;
  localparam int RS_Q_W = 17;
  localparam int LAT    = 13 + EK_Q_W + (X1_W + 1) / 2 + (X2_W + 1) / 2 + RS_Q_W;

  logic        take;
  logic        cos_le0;
  logic [15:0] eo_a   [NUM_FIELD_CH];
  logic [15:0] ei_a   [NUM_FIELD_CH];
  logic [15:0] kk_a   [NUM_FIELD_CH];
  logic [15:0] refl_a [NUM_FIELD_CH];
  logic        vout   [NUM_FIELD_CH];

  assign busy    = 1'b0;
  assign take    = start && !busy;
  assign cos_le0 = item.cos_theta[15] || (item.cos_theta == 16'sd0);

  assign eo_a[0] = item.eta_out_0;
  assign eo_a[1] = item.eta_out_1;
  assign eo_a[2] = item.eta_out_2;
  assign ei_a[0] = item.eta_in_0;
  assign ei_a[1] = item.eta_in_1;
  assign ei_a[2] = item.eta_in_2;
  assign kk_a[0] = item.absorb_0;
  assign kk_a[1] = item.absorb_1;
  assign kk_a[2] = item.absorb_2;

  for (genvar ch = 0; ch < NUM_FIELD_CH; ch++) begin : g_ch
    if (ch < CHANNELS) begin : g_on
      // squares of numerators and denominator
      logic        v1;
      logic [31:0] ne1, nk1, d1;
      logic [14:0] c1;
      logic        z1;
      logic        sat_e, sat_k;

      always_ff @(posedge clk) begin
        if (rst) begin
          v1 <= 1'b0;
        end else begin
          v1 <= take;
        end
        ne1 <= 32'(ei_a[ch]) * 32'(ei_a[ch]);
        nk1 <= 32'(kk_a[ch]) * 32'(kk_a[ch]);
        d1  <= 32'(eo_a[ch]) * 32'(eo_a[ch]);
        c1  <= item.cos_theta[14:0];
        z1  <= cos_le0;
      end

      assign sat_e = ({12'b0, ne1} >= {d1, 12'b0});
      assign sat_k = ({12'b0, nk1} >= {d1, 12'b0});

      // squared relative index and absorption ratios
      logic              ve, vk_unused_free;
      logic [EK_Q_W-1:0] qe, qk;
      logic [14:0]       ce;
      logic              ze, sat_e2, sat_k2;

      fcr_div #(.NUM_W(48), .DEN_W(32), .Q_W(EK_Q_W), .SIDE_W(17)) u_div_e (
        .clk      (clk),
        .rst      (rst),
        .in_valid (v1),
        .num      ({ne1, 16'b0}),
        .den      (d1),
        .side_in  ({z1, c1, sat_e}),
        .out_valid(ve),
        .quo      (qe),
        .side_out ({ze, ce, sat_e2})
      );

      fcr_div #(.NUM_W(48), .DEN_W(32), .Q_W(EK_Q_W), .SIDE_W(1)) u_div_k (
        .clk      (clk),
        .rst      (rst),
        .in_valid (v1),
        .num      ({nk1, 16'b0}),
        .den      (d1),
        .side_in  (sat_k),
        .out_valid(vk_unused_free),
        .quo      (qk),
        .side_out (sat_k2)
      );

      logic [29:0] csq;
      assign csq = 30'(ce) * 30'(ce);

      logic        v3;
      logic [27:0] e3, k3;
      logic [15:0] cos3;
      logic [16:0] sin3;
      logic [14:0] c3;
      logic        z3;

      always_ff @(posedge clk) begin
        if (rst) begin
          v3 <= 1'b0;
        end else begin
          v3 <= ve && vk_unused_free;
        end
        e3   <= sat_e2 ? RATIO_SQ_MAX : qe;
        k3   <= sat_k2 ? RATIO_SQ_MAX : qk;
        cos3 <= csq[29:14];
        sin3 <= ONE_Q16 - {1'b0, csq[29:14]};
        c3   <= ce;
        z3   <= ze;
      end

      // t0 = E2 - K2 - sin2
      logic signed [29:0] t0_c;
      assign t0_c = $signed({2'b00, e3}) - $signed({2'b00, k3}) - $signed({13'b0, sin3});

      logic               v4;
      logic signed [29:0] t0_4;
      logic [28:0]        mag4;
      logic [55:0]        ek4;
      logic [15:0]        cos4;
      logic [16:0]        sin4;
      logic [14:0]        c4;
      logic               z4;

      always_ff @(posedge clk) begin
        if (rst) begin
          v4 <= 1'b0;
        end else begin
          v4 <= v3;
        end
        t0_4 <= t0_c;
        mag4 <= t0_c[29] ? 29'(-t0_c) : 29'(t0_c);
        ek4  <= 56'(e3) * 56'(k3);
        cos4 <= cos3;
        sin4 <= sin3;
        c4   <= c3;
        z4   <= z3;
      end

      logic               v5;
      logic signed [29:0] t0_5;
      logic [57:0]        sq5;
      logic [55:0]        ek5;
      logic [15:0]        cos5;
      logic [16:0]        sin5;
      logic [14:0]        c5;
      logic               z5;

      always_ff @(posedge clk) begin
        if (rst) begin
          v5 <= 1'b0;
        end else begin
          v5 <= v4;
        end
        t0_5 <= t0_4;
        sq5  <= 58'(mag4) * 58'(mag4);
        ek5  <= ek4;
        cos5 <= cos4;
        sin5 <= sin4;
        c5   <= c4;
        z5   <= z4;
      end

      logic               v6;
      logic signed [29:0] t0_6;
      logic [X1_W-1:0]    x6;
      logic [15:0]        cos6;
      logic [16:0]        sin6;
      logic [14:0]        c6;
      logic               z6;

      always_ff @(posedge clk) begin
        if (rst) begin
          v6 <= 1'b0;
        end else begin
          v6 <= v5;
        end
        t0_6 <= t0_5;
        x6   <= X1_W'(sq5) + X1_W'({ek5, 2'b00});
        cos6 <= cos5;
        sin6 <= sin5;
        c6   <= c5;
        z6   <= z5;
      end

      // a2b2 = sqrt(t0^2 + 4 E2 K2)
      logic               vr1;
      logic [29:0]        r1;
      logic signed [29:0] t0_r;
      logic [15:0]        cos_r;
      logic [16:0]        sin_r;
      logic [14:0]        c_r;
      logic               z_r;

      fcr_sqrt #(.IN_W(X1_W), .SIDE_W(79)) u_sqrt_ab (
        .clk      (clk),
        .rst      (rst),
        .in_valid (v6),
        .x        (x6),
        .side_in  ({t0_6, cos6, sin6, c6, z6}),
        .out_valid(vr1),
        .root     (r1),
        .side_out ({t0_r, cos_r, sin_r, c_r, z_r})
      );

      logic signed [31:0] sum_c;
      assign sum_c = $signed({2'b00, r1}) + 32'(t0_r);

      logic        v7;
      logic [30:0] sum7, t1_7;
      logic [29:0] ab7;
      logic [15:0] cos7;
      logic [16:0] sin7;
      logic [14:0] c7;
      logic        z7;

      always_ff @(posedge clk) begin
        if (rst) begin
          v7 <= 1'b0;
        end else begin
          v7 <= vr1;
        end
        sum7 <= sum_c[31] ? '0 : sum_c[30:0];
        t1_7 <= 31'(r1) + 31'(cos_r);
        ab7  <= r1;
        cos7 <= cos_r;
        sin7 <= sin_r;
        c7   <= c_r;
        z7   <= z_r;
      end

      // a = sqrt((a2b2 + t0) / 2)
      logic        vr2;
      logic [22:0] a_r;
      logic [29:0] ab_r;
      logic [30:0] t1_r;
      logic [15:0] cos_q;
      logic [16:0] sin_q;
      logic [14:0] c_q;
      logic        z_q;

      fcr_sqrt #(.IN_W(X2_W), .SIDE_W(110)) u_sqrt_a (
        .clk      (clk),
        .rst      (rst),
        .in_valid (v7),
        .x        ({sum7, 15'b0}),
        .side_in  ({ab7, t1_7, cos7, sin7, c7, z7}),
        .out_valid(vr2),
        .root     (a_r),
        .side_out ({ab_r, t1_r, cos_q, sin_q, c_q, z_q})
      );

      logic [37:0] ca_c;
      assign ca_c = 38'(c_q) * 38'(a_r);

      logic        v8;
      logic [23:0] t2_8;
      logic [29:0] ab8;
      logic [30:0] t1_8;
      logic [15:0] cos8;
      logic [16:0] sin8;
      logic        z8;

      always_ff @(posedge clk) begin
        if (rst) begin
          v8 <= 1'b0;
        end else begin
          v8 <= vr2;
        end
        t2_8 <= ca_c[37:14];
        ab8  <= ab_r;
        t1_8 <= t1_r;
        cos8 <= cos_q;
        sin8 <= sin_q;
        z8   <= z_q;
      end

      logic        v9;
      logic [45:0] ma9;
      logic [33:0] mb9;
      logic [40:0] t4_9;
      logic [31:0] dn9;
      logic [30:0] nn9;
      logic        neg9;
      logic        z9;

      always_ff @(posedge clk) begin
        if (rst) begin
          v9 <= 1'b0;
        end else begin
          v9 <= v8;
        end
        ma9  <= 46'(cos8) * 46'(ab8);
        mb9  <= 34'(sin8) * 34'(sin8);
        t4_9 <= 41'(t2_8) * 41'(sin8);
        dn9  <= 32'(t1_8) + 32'(t2_8);
        nn9  <= t1_8 - 31'(t2_8);
        neg9 <= (t1_8 < 31'(t2_8));
        z9   <= z8;
      end

      logic        v10;
      logic [46:0] t3_10;
      logic [40:0] t4_10;
      logic [31:0] dn10;
      logic [30:0] nn10;
      logic        neg10, z10;

      always_ff @(posedge clk) begin
        if (rst) begin
          v10 <= 1'b0;
        end else begin
          v10 <= v9;
        end
        t3_10 <= 47'(ma9) + 47'(mb9);
        t4_10 <= t4_9;
        dn10  <= dn9;
        nn10  <= nn9;
        neg10 <= neg9;
        z10   <= z9;
      end

      logic        v11;
      logic [46:0] pn11;
      logic [47:0] pd11;
      logic [46:0] sn11;
      logic [31:0] sd11;
      logic        neg11, den0_11, z11;

      always_ff @(posedge clk) begin
        if (rst) begin
          v11 <= 1'b0;
        end else begin
          v11 <= v10;
        end
        pn11    <= (t3_10 > 47'(t4_10)) ? t3_10 - 47'(t4_10) : '0;
        pd11    <= 48'(t3_10) + 48'(t4_10);
        sn11    <= neg10 ? '0 : {nn10, 16'b0};
        sd11    <= dn10;
        neg11   <= neg10;
        den0_11 <= (dn10 == '0);
        z11     <= z10;
      end

      // rs and the p ratio
      logic              vs, vp;
      logic [RS_Q_W-1:0] qs, qp;
      logic              neg_s, den0_s, z_p;

      fcr_div #(.NUM_W(47), .DEN_W(32), .Q_W(RS_Q_W), .SIDE_W(2)) u_div_rs (
        .clk      (clk),
        .rst      (rst),
        .in_valid (v11),
        .num      (sn11),
        .den      (sd11),
        .side_in  ({neg11, den0_11}),
        .out_valid(vs),
        .quo      (qs),
        .side_out ({neg_s, den0_s})
      );

      fcr_div #(.NUM_W(63), .DEN_W(48), .Q_W(RS_Q_W), .SIDE_W(1)) u_div_p (
        .clk      (clk),
        .rst      (rst),
        .in_valid (v11),
        .num      ({pn11, 16'b0}),
        .den      (pd11),
        .side_in  (z11),
        .out_valid(vp),
        .quo      (qp),
        .side_out (z_p)
      );

      logic        v12;
      logic [16:0] rs12, p12;
      logic        z12;

      always_ff @(posedge clk) begin
        if (rst) begin
          v12 <= 1'b0;
        end else begin
          v12 <= vs && vp;
        end
        rs12 <= den0_s ? ONE_Q16 : (neg_s ? '0 : qs);
        p12  <= qp;
        z12  <= z_p;
      end

      logic [33:0] rp_c;
      assign rp_c = 34'(rs12) * 34'(p12);

      logic        v13;
      logic [16:0] rs13, rp13;
      logic        z13;

      always_ff @(posedge clk) begin
        if (rst) begin
          v13 <= 1'b0;
        end else begin
          v13 <= v12;
        end
        rs13 <= rs12;
        rp13 <= rp_c[32:16];
        z13  <= z12;
      end

      logic [17:0] sum_r;
      logic [15:0] r_c;
      assign sum_r = 18'(rs13) + 18'(rp13);
      assign r_c   = (sum_r[17:2] > ONE_Q15) ? ONE_Q15 : sum_r[17:2];

      logic        vo;
      logic [15:0] refl_q;

      always_ff @(posedge clk) begin
        if (rst) begin
          vo <= 1'b0;
        end else begin
          vo <= v13;
        end
        refl_q <= z13 ? '0 : r_c;
      end

      assign refl_a[ch] = refl_q;
      assign vout[ch]   = vo;
    end else begin : g_off
      assign refl_a[ch] = '0;
      assign vout[ch]   = 1'b1;
    end
  end

  assign done          = vout[0] && vout[1] && vout[2];
  assign result.refl_0 = refl_a[0];
  assign result.refl_1 = refl_a[1];
  assign result.refl_2 = refl_a[2];

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    take |-> ##LAT done)
    else $error("transfer not followed by a result at fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, LAT))
    else $error("result without a matching transfer");

  a_zero_cos: assert property (@(posedge clk) disable iff (rst)
    (take && cos_le0) |-> ##LAT (result == '0))
    else $error("non-positive cosine gave non-zero reflectance");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.refl_0 <= ONE_Q15) && (result.refl_1 <= ONE_Q15)
             && (result.refl_2 <= ONE_Q15))
    else $error("reflectance above one");
`endif

endmodule

`default_nettype wire
